### src/pale_pkg.sv
// Shared types, constants, request codes and status codes for the packed list engine.
package pale_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int WORD_WIDTH = 32;
  localparam int ADDR_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  // Request codes
  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_INSERT = 3'd1;
  localparam logic [2:0] REQ_DELETE = 3'd2;
  localparam logic [2:0] REQ_FIND   = 3'd3;
  localparam logic [2:0] REQ_MINMAX = 3'd4;
  localparam logic [2:0] REQ_SORT   = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BAD_POS = 2'd3;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

endpackage

### src/pale_ram.sv
// Generic single-port RAM with registered read.
module pale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/packed_array_list_engine_unit.sv
// Top level of the packed list engine: request sequencer around one RAM.
//
//  channel   | dir | tdata fields (low bit up)                        | tuser
//  s_axis    | in  | req_type[2:0] position[9:3] value_in[41:10]     | ascending
//            |     | (zero-filled to 48 bits)                         |
//  m_axis    | out | status[1:0] value_out[33:2] found[34]            | -
//            |     | index_out[40:35] max_value[72:41] min_value[104:73] |
//            |     | length_out[111:105]                              |
//
// Sequencing: clear and error cases go straight to DONE; insert and delete
// walk the tail one entry at a time, reading each word and writing it back
// one place over; find reads one entry per cycle; min max compares each
// entry first against the minimum, then against the maximum; sort is a
// selection sort that reads, compares and swaps each pair.
// All of these requests share the single RAM port.
// Reset clears the length and the sequencer; the RAM is not cleared.
// s_axis_tready is high only in IDLE; a stalled result holds in DONE.
module packed_array_list_engine_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // req_type, position, value_in
  input  logic         s_axis_tuser,   // ascending
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata    // status, value_out, found, index_out,
                                       // max_value, min_value, length_out
);

  localparam int AW = pale_pkg::ADDR_W;
  localparam int CW = pale_pkg::CNT_W;
  localparam int WW = pale_pkg::WORD_WIDTH;

  typedef enum logic [9:0] {
    IDLE   = 10'b0000000001,
    DISP   = 10'b0000000010,
    SH_RD  = 10'b0000000100,
    SH_WR  = 10'b0000001000,
    INS_WR = 10'b0000010000,
    SCAN   = 10'b0000100000,
    SO_RDI = 10'b0001000000,
    SO_RDJ = 10'b0010000000,
    SO_WR  = 10'b0100000000,
    DONE   = 10'b1000000000
  } state_t;

  state_t state;

  // Latched request
  logic [2:0]          req;
  logic [6:0]          pos;
  pale_pkg::word_t     val;
  logic                asc;
  logic [CW-1:0]       count;

  // Loop variables
  logic [CW-1:0]       i, j;
  logic [CW-1:0]       rd_idx;     // address of the word due on rdata
  logic                rd_valid;
  logic                swap_ph;    // 0: write j, 1: write i
  pale_pkg::word_t     wi, wj;     // sort operands

  // Result
  logic [1:0]          status;
  pale_pkg::word_t     vout, mx, mn;
  logic                found;
  logic [AW-1:0]       idx;

  // RAM port
  logic                we;
  logic [AW-1:0]       addr;
  logic [WW-1:0]       wdata, rdata;

  pale_ram #(.WIDTH(WW), .DEPTH(pale_pkg::LIST_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  pale_pkg::word_t rword;
  assign rword = pale_pkg::word_t'(rdata);

  // Shared comparator: a < b signed
  pale_pkg::word_t cmp_a, cmp_b;
  logic            cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    cmp_a = rword;
    cmp_b = mn;
    if (state == SO_WR) begin
      cmp_a = asc ? wj : wi;
      cmp_b = asc ? wi : wj;
    end else if (state == SCAN && req == pale_pkg::REQ_MINMAX && swap_ph) begin
      cmp_a = mx;
      cmp_b = rword;
    end
  end

  assign s_axis_tready = (state == IDLE);
  assign m_axis_tvalid = (state == DONE);
  assign m_axis_tdata = {count, mn, mx, idx, found, vout, status};

  // RAM address and write control
  always_comb begin
    we = 1'b0;
    addr = i[AW-1:0];
    wdata = val;
    unique case (state)
      SH_RD: begin
        addr = (req == pale_pkg::REQ_INSERT) ? AW'(i - CW'(1)) : AW'(i + CW'(1));
      end
      SH_WR: begin
        we = 1'b1;
        addr = i[AW-1:0];
        wdata = rdata;
      end
      INS_WR: begin
        we = 1'b1;
        addr = pos[AW-1:0];
      end
      SCAN: addr = i[AW-1:0];
      SO_RDI: addr = i[AW-1:0];
      SO_RDJ: addr = j[AW-1:0];
      SO_WR: begin
        // wj is latched in the first SO_WR cycle; write only after that
        we = cmp_lt && !rd_valid;
        addr = swap_ph ? i[AW-1:0] : j[AW-1:0];
        wdata = swap_ph ? wj : wi;
      end
      default: addr = pos[AW-1:0];
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      rd_valid <= 1'b0;
      swap_ph <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            req <= s_axis_tdata[2:0];
            pos <= s_axis_tdata[9:3];
            val <= pale_pkg::word_t'(s_axis_tdata[10 +: WW]);
            asc <= s_axis_tuser;
            status <= pale_pkg::ST_OK;
            vout <= '0;
            found <= 1'b0;
            idx <= '0;
            mx <= '0;
            mn <= '0;
            state <= DISP;
          end
        end
        DISP: begin
          rd_valid <= 1'b0;
          swap_ph <= 1'b0;
          case (req)
            pale_pkg::REQ_CLEAR: begin
              count <= '0;
              state <= DONE;
            end
            pale_pkg::REQ_INSERT: begin
              if (count >= CW'(pale_pkg::LIST_DEPTH)) begin
                status <= pale_pkg::ST_FULL;
                state <= DONE;
              end else if (CW'(pos) > count) begin
                status <= pale_pkg::ST_BAD_POS;
                state <= DONE;
              end else begin
                i <= count;
                state <= (count == CW'(pos)) ? INS_WR : SH_RD;
              end
            end
            pale_pkg::REQ_DELETE: begin
              if (count == '0) begin
                status <= pale_pkg::ST_EMPTY;
                state <= DONE;
              end else if (CW'(pos) >= count) begin
                status <= pale_pkg::ST_BAD_POS;
                state <= DONE;
              end else begin
                i <= CW'(pos);
                state <= SCAN;
              end
            end
            pale_pkg::REQ_FIND: begin
              i <= '0;
              state <= (count != '0) ? SCAN : DONE;
            end
            pale_pkg::REQ_MINMAX: begin
              i <= '0;
              if (count == '0) begin
                status <= pale_pkg::ST_EMPTY;
                state <= DONE;
              end else state <= SCAN;
            end
            pale_pkg::REQ_SORT: begin
              i <= '0;
              j <= CW'(1);
              state <= (count > CW'(1)) ? SO_RDI : DONE;
            end
            default: state <= DONE;
          endcase
        end
        // Shift one word: read neighbor, then write it at i
        SH_RD: state <= SH_WR;
        SH_WR: begin
          if (req == pale_pkg::REQ_INSERT) begin
            if (i - CW'(1) != CW'(pos)) i <= i - CW'(1);
            state <= (i - CW'(1) == CW'(pos)) ? INS_WR : SH_RD;
          end else begin
            if (i + CW'(2) >= count) begin
              count <= count - CW'(1);
              state <= DONE;
            end else begin
              i <= i + CW'(1);
              state <= SH_RD;
            end
          end
        end
        INS_WR: begin
          count <= count + CW'(1);
          state <= DONE;
        end
        // Stream reads: the read is registered, so data arrives in the cycle after its address
        SCAN: begin
          if (req == pale_pkg::REQ_DELETE) begin
            // first read at pos gives the removed word
            if (!rd_valid) rd_valid <= 1'b1;
            else begin
              vout <= rword;
              rd_valid <= 1'b0;
              if (i + CW'(1) >= count) begin
                count <= count - CW'(1);
                state <= DONE;
              end else state <= SH_RD;
            end
          end else if (req == pale_pkg::REQ_FIND) begin
            if (rd_valid && rword == val) begin
              found <= 1'b1;
              idx <= rd_idx[AW-1:0];
              state <= DONE;
            end else if (rd_valid && rd_idx + CW'(1) >= count) begin
              state <= DONE;
            end else begin
              rd_valid <= (i < count);
              rd_idx <= i;
              if (i < count) i <= i + CW'(1);
            end
          end else begin
            // min max: alternate compare of min then max on the same word
            if (rd_valid) begin
              if (!swap_ph) begin
                if (rd_idx == '0) begin
                  mn <= rword;
                  mx <= rword;
                end else if (cmp_lt) mn <= rword;
                swap_ph <= 1'b1;
              end else begin
                if (rd_idx != '0 && cmp_lt) mx <= rword;
                swap_ph <= 1'b0;
                rd_valid <= 1'b0;
                if (rd_idx + CW'(1) >= count) state <= DONE;
                else i <= rd_idx + CW'(1);
              end
            end else begin
              rd_valid <= 1'b1;
              rd_idx <= i;
            end
          end
        end
        // Selection sort: read i, read j, compare and swap in two writes
        SO_RDI: state <= SO_RDJ;
        SO_RDJ: begin
          wi <= rword;
          state <= SO_WR;
          swap_ph <= 1'b0;
          rd_valid <= 1'b1;
        end
        SO_WR: begin
          if (rd_valid) begin
            wj <= rword;
            rd_valid <= 1'b0;
          end else if (!swap_ph && cmp_lt) begin
            swap_ph <= 1'b1;
          end else begin
            swap_ph <= 1'b0;
            if (j + CW'(1) < count) begin
              j <= j + CW'(1);
              state <= SO_RDI;
            end else if (i + CW'(2) < count) begin
              i <= i + CW'(1);
              j <= i + CW'(2);
              state <= SO_RDI;
            end else state <= DONE;
          end
        end
        DONE: if (m_axis_tready) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  // Length never exceeds the depth
  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(pale_pkg::LIST_DEPTH))
    else $error("list length beyond depth");

  // RAM is written only inside a request
  assert property (@(posedge clk) disable iff (rst)
    we |-> (state != IDLE && state != DONE))
    else $error("RAM write outside a request");

  // Result holds while stalled
  assert property (@(posedge clk) disable iff (rst)
    (state == DONE && !m_axis_tready) |=> (state == DONE && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // Failed request leaves length unchanged
  assert property (@(posedge clk) disable iff (rst)
    (state == DONE && status != pale_pkg::ST_OK) |-> $stable(count))
    else $error("length changed on failed request");

endmodule
